### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/str_pkg.sv
// ---------------------------------------------------------------------------
// Segment tree range sum package
// Shared widths, operation codes and the result type.
// ---------------------------------------------------------------------------
`default_nettype none

package str_pkg;

    localparam int LEAVES_DEFAULT = 1024;

    localparam int POSITION_W = 10;
    localparam int VALUE_W    = 32;
    localparam int BOUND_W    = 11;
    localparam int SUM_W      = 32;

    localparam int S_TDATA_W  = 64;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = 32;

    localparam logic OP_SET   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                    valid;
        logic signed [SUM_W-1:0] sum;
    } res_t;

endpackage

`default_nettype wire

### rtl/str_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module str_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire logic                                      clk,
    input  wire logic                                      wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                          wr_data,
    input  wire logic                                      rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/str_engine.sv
// ---------------------------------------------------------------------------
// Segment tree engine
// Clears the node store, walks a leaf update up to the root, and walks a
// range query bottom-up with up to two node reads per level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module str_engine #(
    parameter int LEAVES = str_pkg::LEAVES_DEFAULT
) (
    input  wire logic                                   clk,
    input  wire logic                                   rstn,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic                                   operation,
    input  wire logic [str_pkg::POSITION_W-1:0]         position,
    input  wire logic signed [str_pkg::VALUE_W-1:0]     value,
    input  wire logic [str_pkg::BOUND_W-1:0]            range_low,
    input  wire logic [str_pkg::BOUND_W-1:0]            range_high,
    input  wire logic                                   out_free,
    output str_pkg::res_t                               res,
    output logic                                        wr_en,
    output logic [$clog2(2*LEAVES)-1:0]                 wr_addr,
    output logic [str_pkg::SUM_W-1:0]                   wr_data,
    output logic                                        rd_a_en,
    output logic [$clog2(2*LEAVES)-1:0]                 rd_a_addr,
    input  wire logic [str_pkg::SUM_W-1:0]              rd_a_data,
    output logic                                        rd_b_en,
    output logic [$clog2(2*LEAVES)-1:0]                 rd_b_addr,
    input  wire logic [str_pkg::SUM_W-1:0]              rd_b_data
);

    import str_pkg::*;

    localparam int NODES = 2 * LEAVES;
    localparam int AW    = $clog2(NODES);
    localparam int IW    = $clog2(NODES + 1);
    localparam int BW    = (IW > BOUND_W) ? IW : BOUND_W;
    localparam int PW    = (IW > POSITION_W) ? IW : POSITION_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SLEAF,
        ST_SWALK,
        ST_QRUN,
        ST_QDONE
    } state_t;

    state_t           state_reg, state_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [SUM_W-1:0] cur_reg, cur_next;
    logic [IW-1:0]    lo_reg, lo_next;
    logic [IW-1:0]    hi_reg, hi_next;
    logic [SUM_W-1:0] acc_reg, acc_next;
    logic             pend_a_reg, pend_a_next;
    logic             pend_b_reg, pend_b_next;

    logic [BW-1:0]    lo_ext, hi_ext, lo_sat, hi_sat;
    logic [IW-1:0]    lo_idx, hi_idx, hi_m1;
    logic [PW-1:0]    pos_ext;
    logic             pos_ok;
    logic [AW-1:0]    leaf_idx, parent;
    logic [SUM_W-1:0] walk_sum, acc_add;

    always_comb begin
        lo_ext   = BW'(range_low);
        hi_ext   = BW'(range_high);
        lo_sat   = (lo_ext > BW'(LEAVES)) ? BW'(LEAVES) : lo_ext;
        hi_sat   = (hi_ext > BW'(LEAVES)) ? BW'(LEAVES) : hi_ext;
        lo_idx   = IW'(lo_sat) + IW'(LEAVES);
        hi_idx   = IW'(hi_sat) + IW'(LEAVES);
        pos_ext  = PW'(position);
        pos_ok   = pos_ext < PW'(LEAVES);
        leaf_idx = AW'(pos_ext) + AW'(LEAVES);
        parent   = idx_reg >> 1;
        walk_sum = cur_reg + rd_a_data;
        hi_m1    = hi_reg - IW'(1);
        acc_add  = acc_reg + (pend_a_reg ? rd_a_data : '0) + (pend_b_reg ? rd_b_data : '0);
    end

    always_comb begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        idx_next    = idx_reg;
        cur_next    = cur_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        acc_next    = acc_reg;
        pend_a_next = pend_a_reg;
        pend_b_next = pend_b_reg;
        in_ready    = (state_reg == ST_IDLE);
        res         = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;
        rd_a_en     = 1'b0;
        rd_a_addr   = '0;
        rd_b_en     = 1'b0;
        rd_b_addr   = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(NODES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_valid) begin
                    if (operation == OP_QUERY) begin
                        lo_next     = lo_idx;
                        hi_next     = hi_idx;
                        acc_next    = '0;
                        pend_a_next = 1'b0;
                        pend_b_next = 1'b0;
                        state_next  = ST_QRUN;
                    end else if (pos_ok) begin
                        idx_next   = leaf_idx;
                        cur_next   = SUM_W'(value);
                        state_next = ST_SLEAF;
                    end
                end
            end
            ST_SLEAF: begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = cur_reg;
                if (idx_reg == AW'(1)) begin
                    state_next = ST_IDLE;
                end else begin
                    rd_a_en    = 1'b1;
                    rd_a_addr  = idx_reg ^ AW'(1);
                    state_next = ST_SWALK;
                end
            end
            ST_SWALK: begin
                wr_en    = 1'b1;
                wr_addr  = parent;
                wr_data  = walk_sum;
                cur_next = walk_sum;
                idx_next = parent;
                if (parent == AW'(1)) begin
                    state_next = ST_IDLE;
                end else begin
                    rd_a_en   = 1'b1;
                    rd_a_addr = parent ^ AW'(1);
                end
            end
            ST_QRUN: begin
                acc_next = acc_add;
                if (lo_reg < hi_reg) begin
                    rd_a_en     = lo_reg[0];
                    rd_a_addr   = lo_reg[AW-1:0];
                    rd_b_en     = hi_reg[0];
                    rd_b_addr   = hi_m1[AW-1:0];
                    lo_next     = (lo_reg + IW'(lo_reg[0])) >> 1;
                    hi_next     = hi_reg >> 1;
                    pend_a_next = lo_reg[0];
                    pend_b_next = hi_reg[0];
                end else begin
                    pend_a_next = 1'b0;
                    pend_b_next = 1'b0;
                    state_next  = ST_QDONE;
                end
            end
            ST_QDONE: begin
                res.sum = acc_reg;
                if (out_free) begin
                    res.valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
        idx_reg    <= idx_next;
        cur_reg    <= cur_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        acc_reg    <= acc_next;
        pend_a_reg <= pend_a_next;
        pend_b_reg <= pend_b_next;
    end

    `ASSERT_IMPL(a_no_rw_clash, clk, rstn, wr_en && rd_a_en, wr_addr != rd_a_addr, "read hits node being written")
    `ASSERT_IMPL(a_walk_internal, clk, rstn, state_reg == ST_SWALK, wr_addr < AW'(LEAVES), "update walk wrote a leaf")
    `ASSERT_IMPL(a_query_no_write, clk, rstn, state_reg == ST_QRUN || state_reg == ST_QDONE, !wr_en, "write during query")
    `ASSERT_IMPL(a_res_free, clk, rstn, res.valid, out_free, "result issued into a full output")
    `ASSERT_NEXT(a_clear_done, clk, rstn, state_reg == ST_CLEAR && clr_reg == AW'(NODES - 1), state_reg == ST_IDLE, "clear pass overran")

endmodule

`default_nettype wire

### rtl/segment_tree_range_sum.sv
// ---------------------------------------------------------------------------
// Segment tree range sum
// Bottom-up segment tree of 32-bit wrapping sums over LEAVES leaves.
// ---------------------------------------------------------------------------
// After reset the node store is cleared, one node a cycle, all 2*LEAVES
// nodes; no request is taken until then. A set request (tuser 0) writes one
// leaf and updates its ancestors: the request is taken, the leaf is written,
// then each parent up to the root is rewritten by a read-add-write of the
// sibling. A query (tuser 1) reads the lower and upper boundary node of each
// level in the same cycle from two mirrored node stores. Its steps: the
// request is taken, each level is read, the last reads are added and, once
// the output is free, the result is loaded. One request is worked on at a
// time; the result register lets the next request start while a result
// waits. Sets at a position of LEAVES or more are dropped; query bounds
// saturate.
// ---------------------------------------------------------------------------
`default_nettype none

module segment_tree_range_sum #(
    parameter int LEAVES = str_pkg::LEAVES_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // position[9:0], value[41:10], range_low[52:42], range_high[63:53]
    input  wire logic [str_pkg::S_TDATA_W-1:0] s_tdata,
    // operation[0]
    input  wire logic [str_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // range_sum[31:0]
    output logic [str_pkg::M_TDATA_W-1:0]      m_tdata
);

    import str_pkg::*;

    localparam int NODES = 2 * LEAVES;
    localparam int AW    = $clog2(NODES);

    res_t             res;
    logic             out_free;
    logic             wr_en, rd_a_en, rd_b_en;
    logic [AW-1:0]    wr_addr, rd_a_addr, rd_b_addr;
    logic [SUM_W-1:0] wr_data, rd_a_data, rd_b_data;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    str_engine #(
        .LEAVES (LEAVES)
    ) u_engine (
        .clk        (aclk),
        .rstn       (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .operation  (s_tuser[0]),
        .position   (s_tdata[9:0]),
        .value      (s_tdata[41:10]),
        .range_low  (s_tdata[52:42]),
        .range_high (s_tdata[63:53]),
        .out_free   (out_free),
        .res        (res),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_a_en    (rd_a_en),
        .rd_a_addr  (rd_a_addr),
        .rd_a_data  (rd_a_data),
        .rd_b_en    (rd_b_en),
        .rd_b_addr  (rd_b_addr),
        .rd_b_data  (rd_b_data)
    );

    str_ram #(
        .WIDTH (SUM_W),
        .DEPTH (NODES)
    ) u_ram_a (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_a_en),
        .rd_addr (rd_a_addr),
        .rd_data (rd_a_data)
    );

    str_ram #(
        .WIDTH (SUM_W),
        .DEPTH (NODES)
    ) u_ram_b (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_b_en),
        .rd_addr (rd_b_addr),
        .rd_data (rd_b_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res.valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (res.valid) begin
            m_tdata_reg <= M_TDATA_W'(res.sum);
        end
    end

endmodule

`default_nettype wire
